### rtl/core/etdc_pkg.sv
`default_nettype none
package etdc_pkg;
    localparam int unsigned ExtExpW  = 15;
    localparam int unsigned SigW     = 64;
    localparam int unsigned LzW      = 7;
    localparam int unsigned BeW      = 17;
    localparam logic [ExtExpW-1:0] ExtExpMax = 15'h7FFF;
    localparam int signed   ExtBias  = 16383;
    localparam int signed   DblBias  = 1023;
    localparam logic [10:0] DblExpMax = 11'h7FF;

    typedef struct packed {
        logic             sign;
        logic             is_inf;
        logic             is_zero;
        logic [ExtExpW-1:0] exp;
        logic [SigW-1:0]  sig;
    } stage1_t;

    typedef struct packed {
        logic             sign;
        logic             is_inf;
        logic             is_zero;
        logic signed [BeW-1:0] be;
        logic [SigW-1:0]  sig;
    } stage2_t;

    typedef struct packed {
        logic             sign;
        logic             is_inf;
        logic             is_zero;
        logic signed [BeW-1:0] be;
        logic [SigW-1:0]  q;
        logic             rnd_up;
    } stage3_t;
endpackage
`default_nettype wire

### rtl/core/etdc_if.sv
`default_nettype none
interface etdc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sign_and_exponent;
    logic [63:0] significand;
    modport source (output valid, sign_and_exponent, significand, input ready);
    modport sink (input valid, sign_and_exponent, significand, output ready);
endinterface

interface etdc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] double_bits;
    modport source (output valid, double_bits, input ready);
    modport sink (input valid, double_bits, output ready);
endinterface
`default_nettype wire

### rtl/core/etdc_norm.sv
`default_nettype none
// Leading-zero count and left normalize of the significand.
module etdc_norm (
    input  var etdc_pkg::stage1_t in_stage,
    output var etdc_pkg::stage2_t out_stage
);
    logic [etdc_pkg::LzW-1:0] lz;
    logic                     found;

    always_comb
    begin
        lz    = '0;
        found = 1'b0;
        for (int i = etdc_pkg::SigW - 1; i >= 0; i--)
        begin
            if (!found && in_stage.sig[i])
            begin
                found = 1'b1;
                lz    = etdc_pkg::LzW'(etdc_pkg::SigW - 1 - i);
            end
        end
        out_stage.sign    = in_stage.sign;
        out_stage.is_inf  = in_stage.is_inf;
        out_stage.is_zero = in_stage.is_zero;
        out_stage.sig     = in_stage.sig << lz;
        out_stage.be      = etdc_pkg::BeW'($signed({2'b00, in_stage.exp}))
                          - etdc_pkg::BeW'(etdc_pkg::ExtBias - etdc_pkg::DblBias)
                          - etdc_pkg::BeW'($signed({1'b0, lz}));
    end
endmodule
`default_nettype wire

### rtl/core/etdc_round.sv
`default_nettype none
// Right shift to the final position, collecting the round decision.
module etdc_round (
    input  var etdc_pkg::stage2_t in_stage,
    output var etdc_pkg::stage3_t out_stage
);
    logic [6:0]  sh;
    logic        sh_big;
    logic [63:0] mask;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] q;

    always_comb
    begin
        sh_big = 1'b0;
        sh     = 7'd11;
        mask   = '0;
        if (in_stage.be < 1)
        begin
            if (in_stage.be < -52)
                sh_big = 1'b1;
            else
                sh = 7'(12 - in_stage.be);
        end
        if (sh == 7'd64)
        begin
            q    = '0;
            rem  = in_stage.sig;
            half = 64'h8000_0000_0000_0000;
        end
        else
        begin
            mask = (64'd1 << sh[5:0]) - 64'd1;
            q    = in_stage.sig >> sh[5:0];
            rem  = in_stage.sig & mask;
            half = 64'd1 << (sh[5:0] - 6'd1);
        end
        if (sh_big)
        begin
            q   = '0;
            rem = '0;
            half = 64'd1;
        end
        out_stage.sign    = in_stage.sign;
        out_stage.is_inf  = in_stage.is_inf;
        out_stage.is_zero = in_stage.is_zero | sh_big;
        out_stage.be      = in_stage.be;
        out_stage.q       = q;
        out_stage.rnd_up  = (rem > half) || (rem == half && q[0]);
    end
endmodule
`default_nettype wire

### rtl/core/etdc_pack.sv
`default_nettype none
// Increment, carry-out exponent fix, overflow and final encoding.
module etdc_pack (
    input  var etdc_pkg::stage3_t in_stage,
    output logic [63:0]           bits
);
    logic [53:0]            q;
    logic signed [etdc_pkg::BeW-1:0] be;

    always_comb
    begin
        q  = in_stage.q[53:0] + {53'd0, in_stage.rnd_up};
        be = in_stage.be;
        if (in_stage.be >= 1 && q[53])
        begin
            q  = q >> 1;
            be = be + etdc_pkg::BeW'(1);
        end
        // A zero significand stays zero even when its exponent is huge, unless the exponent is 0x7FFF.
        if (in_stage.is_inf)
            bits = {in_stage.sign, etdc_pkg::DblExpMax, 52'd0};
        else if (in_stage.is_zero)
            bits = {in_stage.sign, 63'd0};
        else if (in_stage.be >= 1 && be >= 2047)
            bits = {in_stage.sign, etdc_pkg::DblExpMax, 52'd0};
        else if (in_stage.be >= 1)
            bits = {in_stage.sign, be[10:0], q[51:0]};
        else
            bits = {in_stage.sign, 10'd0, q[52:0]};
    end
endmodule
`default_nettype wire

### rtl/core/extended_to_double_convert_core.sv
`default_nettype none
// Converts an 80-bit extended value (sign/exponent word plus 64-bit significand
// with explicit integer bit) to IEEE binary64 bits, round to nearest even,
// overflow to infinity, gradual underflow rounded once. Exponent 0x7FFF maps to
// infinity (NaN payloads are dropped); any other zero significand gives signed zero.
// Four register stages: input capture, normalize (leading-zero count and
// shift), round-position shift, and increment/pack into the output register.
// One transaction per cycle sustained; valid bits travel
// with each stage and the whole pipe holds when the output is not taken.
module extended_to_double_convert_core (
    input  wire         clk,
    input  wire         rst_n,
    etdc_in_if.sink     in_ch,
    etdc_out_if.source  out_ch
);
    logic              adv;
    logic [3:0]        v_reg;
    etdc_pkg::stage1_t s1_reg, s1_next;
    etdc_pkg::stage2_t s2_reg, s2_next;
    etdc_pkg::stage3_t s3_reg, s3_next;
    logic [63:0]       out_reg, out_next;

    // Whole pipe advances when the output slot is free or being drained.
    assign adv          = !v_reg[3] || out_ch.ready;
    assign in_ch.ready  = adv;
    assign out_ch.valid = v_reg[3];
    assign out_ch.double_bits = out_reg;

    always_comb
    begin
        s1_next.sign    = in_ch.sign_and_exponent[15];
        s1_next.exp     = in_ch.sign_and_exponent[14:0];
        s1_next.sig     = in_ch.significand;
        s1_next.is_inf  = in_ch.sign_and_exponent[14:0] == etdc_pkg::ExtExpMax;
        s1_next.is_zero = in_ch.significand == '0;
    end

    etdc_norm  u_norm  (.in_stage(s1_reg), .out_stage(s2_next));
    etdc_round u_round (.in_stage(s2_reg), .out_stage(s3_next));
    etdc_pack  u_pack  (.in_stage(s3_reg), .bits(out_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_ch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            out_reg <= out_next;
        end
    end

    // Held output must not change while waiting.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.double_bits))
        else $error("output changed while stalled");
    // Infinity held in the round-stage register reaches the output register as infinity when the pipe advances.
    a_inf: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] && adv && s3_reg.is_inf |=> out_reg[62:52] == 11'h7FF
            && out_reg[51:0] == 52'd0)
        else $error("infinity lost");
    // Stall freezes the valid pipeline.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("valid moved during stall");
endmodule
`default_nettype wire
